// ----- design/sa32_pkg.sv -----
package sa32_pkg;

    // adler-32 modulus and segment limits
    localparam int ADLER_MOD         = 65521;
    localparam int MAX_SEGMENT_BYTES = 8192;
    localparam int POS_MAX           = 16383;
    localparam int POS_W             = 14;
    localparam int SUM_W             = 16;
    localparam int OFFSET_W          = 8;
    localparam int BYTE_W            = 8;
    localparam int FIELD_W           = 32;

    localparam logic [POS_W-1:0] POS_LIMIT =
        POS_W'((MAX_SEGMENT_BYTES < POS_MAX) ? MAX_SEGMENT_BYTES : POS_MAX);

    localparam logic [SUM_W:0] MOD_EXT = (SUM_W+1)'(ADLER_MOD);

    // one accepted input beat
    typedef struct packed {
        logic              last_byte;
        logic [BYTE_W-1:0] byte_value;
    } beat_t;

    // one result beat
    typedef struct packed {
        logic               short_segment;
        logic               sums_match;
        logic [FIELD_W-1:0] received_sum;
        logic [FIELD_W-1:0] computed_sum;
    } result_t;

    // modular add of two values already below the modulus
    function automatic logic [SUM_W-1:0] mod_add(input logic [SUM_W-1:0] x,
                                                 input logic [SUM_W-1:0] y);
        logic [SUM_W:0] s;
        begin
            s = {1'b0, x} + {1'b0, y};
            if (s >= MOD_EXT)
            begin
                s = s - MOD_EXT;
            end
            mod_add = s[SUM_W-1:0];
        end
    endfunction

endpackage

// ----- design/sa32_in_stage.sv -----
module sa32_in_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  sa32_pkg::beat_t in_beat,
    output logic            beat_valid,
    output sa32_pkg::beat_t beat,
    input  logic            beat_take
);

    logic            valid_reg;
    sa32_pkg::beat_t beat_reg;

    // register frees up when empty or when the core takes it this cycle
    assign in_ready   = !valid_reg || beat_take;
    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            beat_reg <= in_beat;
        end
    end

endmodule

// ----- design/sa32_sum_core.sv -----
module sa32_sum_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [sa32_pkg::OFFSET_W-1:0]   field_offset,
    input  logic                            beat_valid,
    input  sa32_pkg::beat_t                 beat,
    output logic                            beat_take,
    output logic                            res_valid,
    input  logic                            res_ready,
    output sa32_pkg::result_t               res
);

    logic [sa32_pkg::SUM_W-1:0]   low_sum_reg;
    logic [sa32_pkg::SUM_W-1:0]   low_sum_next;
    logic [sa32_pkg::SUM_W-1:0]   high_sum_reg;
    logic [sa32_pkg::SUM_W-1:0]   high_sum_next;
    logic [sa32_pkg::POS_W-1:0]   pos_reg;
    logic [sa32_pkg::POS_W-1:0]   pos_next;
    logic [sa32_pkg::FIELD_W-1:0] captured_reg;
    logic [sa32_pkg::FIELD_W-1:0] captured_next;
    logic                         out_valid_reg;
    sa32_pkg::result_t            out_reg;
    sa32_pkg::result_t            out_next;

    logic                         below_limit;
    logic                         in_field;
    logic [sa32_pkg::POS_W-1:0]   offset_ext;
    logic [sa32_pkg::POS_W-1:0]   field_end;
    logic [1:0]                   rel_pos;
    logic [sa32_pkg::BYTE_W-1:0]  sum_byte;
    logic                         is_short;

    // only a last beat needs the result register free or draining this cycle
    assign beat_take = beat_valid && (!beat.last_byte || !out_valid_reg || res_ready);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // checksum field window
    always_comb
    begin
        offset_ext  = sa32_pkg::POS_W'(field_offset);
        field_end   = offset_ext + sa32_pkg::POS_W'(3);
        rel_pos     = pos_reg[1:0] - field_offset[1:0];
        below_limit = pos_reg < sa32_pkg::POS_LIMIT;
        in_field    = below_limit && (pos_reg >= offset_ext) && (pos_reg <= field_end);
        is_short    = (pos_reg < field_end) || (field_end >= sa32_pkg::POS_LIMIT);
    end

    // sum update, capture and position
    always_comb
    begin
        captured_next = captured_reg;
        sum_byte      = beat.byte_value;
        if (in_field)
        begin
            captured_next = captured_reg |
                (sa32_pkg::FIELD_W'(beat.byte_value) << {rel_pos, 3'b000});
            sum_byte      = '0;
        end
        low_sum_next  = sa32_pkg::mod_add(low_sum_reg, sa32_pkg::SUM_W'(sum_byte));
        high_sum_next = sa32_pkg::mod_add(high_sum_reg, low_sum_next);
        pos_next      = below_limit ? (pos_reg + sa32_pkg::POS_W'(1)) : pos_reg;

        out_next.computed_sum  = {high_sum_next, low_sum_next};
        out_next.received_sum  = captured_next;
        out_next.short_segment = is_short;
        out_next.sums_match    = !is_short && ({high_sum_next, low_sum_next} == captured_next);
    end

    // running segment state, cleared after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_sum_reg  <= sa32_pkg::SUM_W'(1);
            high_sum_reg <= '0;
            pos_reg      <= '0;
            captured_reg <= '0;
        end
        else if (beat_take)
        begin
            if (beat.last_byte)
            begin
                low_sum_reg  <= sa32_pkg::SUM_W'(1);
                high_sum_reg <= '0;
                pos_reg      <= '0;
                captured_reg <= '0;
            end
            else
            begin
                low_sum_reg  <= low_sum_next;
                high_sum_reg <= high_sum_next;
                pos_reg      <= pos_next;
                captured_reg <= captured_next;
            end
        end
    end

    // result valid, held until the result beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (beat_take && beat.last_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (beat_take && beat.last_byte)
        begin
            out_reg <= out_next;
        end
    end

`ifndef NO_ASSERTIONS
    // sums stay reduced
    assert property (@(posedge clk) disable iff (!rst_n)
        (low_sum_reg < sa32_pkg::SUM_W'(sa32_pkg::ADLER_MOD)) &&
        (high_sum_reg < sa32_pkg::SUM_W'(sa32_pkg::ADLER_MOD)))
        else $error("adler sum out of range");

    // position never passes the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= sa32_pkg::POS_LIMIT)
        else $error("byte position past limit");

    // a last byte starts a fresh segment
    assert property (@(posedge clk) disable iff (!rst_n)
        beat_take && beat.last_byte |=> pos_reg == '0 && captured_reg == '0)
        else $error("segment state not cleared after last byte");

    // a held result is not overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res_ready |-> !(beat_take && beat.last_byte))
        else $error("result overwritten while stalled");

    // a short segment never matches
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.sums_match && out_reg.short_segment))
        else $error("match flagged on short segment");
`endif

endmodule

// ----- design/segment_adler32_check.sv -----
// Streaming Adler-32 check of one transport segment. Bytes arrive on the slave side one per
// beat, tlast on the final byte. The four bytes starting at field_offset (default 12) are
// summed as zero and captured little-endian as the received checksum. After the last byte one
// result beat leaves on the master side: tdata holds the computed sum (high sum in 31:16) and
// the received field, tuser holds the match and short-segment flags. The block takes one byte
// every cycle unless a last byte is held back; the sum update (two chained add and conditional
// subtract steps) sits combinationally behind the input register. A result beat passes through
// the input register and then the result register; a last byte waits only while an earlier
// result beat is still held. Byte positions saturate at 8192; a field that does not fit below
// that is reported short. Write field_offset only while no segment is in flight.
module segment_adler32_check
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [7:0]  cfg_wdata,      // field_offset
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // byte_value
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // computed_sum [31:0], received_sum [63:32]
    output logic [1:0]  m_axis_tuser    // sums_match [0], short_segment [1]
);

    logic [sa32_pkg::OFFSET_W-1:0] field_offset_reg;
    sa32_pkg::beat_t               in_beat;
    sa32_pkg::beat_t               beat;
    logic                          beat_valid;
    logic                          beat_take;
    sa32_pkg::result_t             res;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_offset_reg <= sa32_pkg::OFFSET_W'(12);
        end
        else if (cfg_wen)
        begin
            field_offset_reg <= cfg_wdata;
        end
    end

    // input beat packing
    always_comb
    begin
        in_beat.byte_value = s_axis_tdata;
        in_beat.last_byte  = s_axis_tlast;
    end

    sa32_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_beat    (in_beat),
        .beat_valid (beat_valid),
        .beat       (beat),
        .beat_take  (beat_take)
    );

    sa32_sum_core u_sum_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .field_offset (field_offset_reg),
        .beat_valid   (beat_valid),
        .beat         (beat),
        .beat_take    (beat_take),
        .res_valid    (m_axis_tvalid),
        .res_ready    (m_axis_tready),
        .res          (res)
    );

    // result beat packing
    assign m_axis_tdata = {res.received_sum, res.computed_sum};
    assign m_axis_tuser = {res.short_segment, res.sums_match};

endmodule
